// ----- hw/rtl/line_follow_pid_steer_macros.svh -----
// Assertion macros shared by the line follower steering RTL.
`ifndef LINE_FOLLOW_PID_STEER_MACROS_SVH
`define LINE_FOLLOW_PID_STEER_MACROS_SVH
`ifndef ASSERT_OFF
`define LFPS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfps same-cycle check failed");
`define LFPS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfps next-cycle check failed");
`else
`define LFPS_ASSERT_IMP(lbl, ante, cons)
`define LFPS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- hw/rtl/lfps_pkg.sv -----
// Package with types, codes and constants of the line follower steering block.
package lfps_pkg;

  localparam int CENTER_COLUMN_DEF = 160;
  localparam int SCAN_ROW_DEF      = 120;
  localparam int WIN_LEFT          = 50;
  localparam int WIN_RIGHT         = 49;
  localparam int ROW_ABOVE         = 2;
  localparam int ROW_BELOW         = 1;

  localparam int Q_FRAC = 12;

  localparam logic [15:0] PROP_GAIN_RST  = 16'd614;
  localparam logic [15:0] DERIV_GAIN_RST = 16'd205;
  localparam logic [15:0] INTEG_GAIN_RST = 16'd0;
  localparam logic [7:0]  THRESHOLD_RST  = 8'd128;
  localparam logic [7:0]  JUNCTION_RST   = 8'd140;
  localparam logic [7:0]  BASE_SPEED_RST = 8'd50;

  localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [2:0] REG_DERIV_GAIN = 3'd1;
  localparam logic [2:0] REG_INTEG_GAIN = 3'd2;
  localparam logic [2:0] REG_THRESHOLD  = 3'd3;
  localparam logic [2:0] REG_JUNCTION   = 3'd4;
  localparam logic [2:0] REG_BASE_SPEED = 3'd5;

  localparam logic [1:0] DEC_FOLLOW   = 2'd0;
  localparam logic [1:0] DEC_JUNCTION = 2'd1;
  localparam logic [1:0] DEC_LOST     = 2'd2;

  localparam int DIV_LEN   = 28;
  localparam int DIV_CNT_W = $clog2(DIV_LEN);

  localparam int MEAN_MAX     = 204799;
  localparam int MEAN_NEG_MAG = 204800;
  localparam int PID_LIM      = 8388608;

  localparam int SCALE_SHORT = 50;
  localparam int SCALE_LONG  = 300;
  localparam int WHEEL_SHIFT = 17;
  localparam int RECIP5      = 13108;
  localparam int RECIP_SHIFT = 16;
  localparam int WHEEL_SAT_T = 1280;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DIV,
    ST_MEAN,
    ST_MUL_P,
    ST_PROP,
    ST_UPD,
    ST_MUL_D,
    ST_DER,
    ST_MUL_IL,
    ST_MUL_IH,
    ST_ISUM,
    ST_INTG,
    ST_PID1,
    ST_PID2,
    ST_CLAMP,
    ST_MUL_WL,
    ST_MUL_WR,
    ST_LOAD
  } lfps_state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_DEC_INT,
    OP_DEC_LOST,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_MEAN,
    OP_MUL_P,
    OP_PROP,
    OP_UPD,
    OP_MUL_D,
    OP_DER,
    OP_MUL_IL,
    OP_MUL_IH,
    OP_ISUM,
    OP_INTG,
    OP_PID1,
    OP_PID2,
    OP_CLAMP,
    OP_MUL_WL,
    OP_MUL_WR,
    OP_LOAD
  } lfps_op_t;

  typedef struct packed {
    logic     pix_en;
    lfps_op_t op;
  } lfps_cmd_t;

  typedef struct packed {
    logic junction;
    logic have_win;
    logic out_free;
  } lfps_stat_t;

endpackage

// ----- hw/rtl/lfps_pix_if.sv -----
// Pixel input channel interface with valid/ready handshake.
interface lfps_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_value;
  logic [8:0] pixel_col;
  logic [7:0] pixel_row;
  logic       frame_end;

  modport source (
    output valid, pixel_value, pixel_col, pixel_row, frame_end,
    input  ready
  );
  modport sink (
    input  valid, pixel_value, pixel_col, pixel_row, frame_end,
    output ready
  );
endinterface

// ----- hw/rtl/lfps_res_if.sv -----
// Steering result channel interface with valid/ready handshake.
interface lfps_res_if;
  logic               valid;
  logic               ready;
  logic signed [8:0]  left_speed;
  logic signed [8:0]  right_speed;
  logic [1:0]         decision;
  logic signed [18:0] mean_offset;

  modport source (
    output valid, left_speed, right_speed, decision, mean_offset,
    input  ready
  );
  modport sink (
    input  valid, left_speed, right_speed, decision, mean_offset,
    output ready
  );
endinterface

// ----- hw/rtl/lfps_ctrl.sv -----
// Controller state machine that sequences pixel intake, the frame decision and the follow steps.
`include "line_follow_pid_steer_macros.svh"
module lfps_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                frame_end,
  output logic                in_ready,
  input  lfps_pkg::lfps_stat_t stat,
  output lfps_pkg::lfps_cmd_t  cmd
);

  localparam int CW = lfps_pkg::DIV_CNT_W;
  localparam logic [CW-1:0] DIV_LAST = CW'(lfps_pkg::DIV_LEN - 1);

  lfps_pkg::lfps_state_t state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lfps_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lfps_pkg::ST_IDLE: begin
        if (in_valid && frame_end) state_nxt = lfps_pkg::ST_DECIDE;
      end
      lfps_pkg::ST_DECIDE: begin
        if (stat.junction) begin
          if (stat.out_free) state_nxt = lfps_pkg::ST_IDLE;
        end else if (stat.have_win) begin
          state_nxt = lfps_pkg::ST_DIV;
        end else if (stat.out_free) begin
          state_nxt = lfps_pkg::ST_IDLE;
        end
      end
      lfps_pkg::ST_DIV: begin
        if (cnt_r == DIV_LAST) state_nxt = lfps_pkg::ST_MEAN;
      end
      lfps_pkg::ST_MEAN:   state_nxt = lfps_pkg::ST_MUL_P;
      lfps_pkg::ST_MUL_P:  state_nxt = lfps_pkg::ST_PROP;
      lfps_pkg::ST_PROP:   state_nxt = lfps_pkg::ST_UPD;
      lfps_pkg::ST_UPD:    state_nxt = lfps_pkg::ST_MUL_D;
      lfps_pkg::ST_MUL_D:  state_nxt = lfps_pkg::ST_DER;
      lfps_pkg::ST_DER:    state_nxt = lfps_pkg::ST_MUL_IL;
      lfps_pkg::ST_MUL_IL: state_nxt = lfps_pkg::ST_MUL_IH;
      lfps_pkg::ST_MUL_IH: state_nxt = lfps_pkg::ST_ISUM;
      lfps_pkg::ST_ISUM:   state_nxt = lfps_pkg::ST_INTG;
      lfps_pkg::ST_INTG:   state_nxt = lfps_pkg::ST_PID1;
      lfps_pkg::ST_PID1:   state_nxt = lfps_pkg::ST_PID2;
      lfps_pkg::ST_PID2:   state_nxt = lfps_pkg::ST_CLAMP;
      lfps_pkg::ST_CLAMP:  state_nxt = lfps_pkg::ST_MUL_WL;
      lfps_pkg::ST_MUL_WL: state_nxt = lfps_pkg::ST_MUL_WR;
      lfps_pkg::ST_MUL_WR: state_nxt = lfps_pkg::ST_LOAD;
      lfps_pkg::ST_LOAD: begin
        if (stat.out_free) state_nxt = lfps_pkg::ST_IDLE;
      end
      default: state_nxt = lfps_pkg::ST_IDLE;
    endcase
  end

  assign cnt_nxt = (state_r == lfps_pkg::ST_DIV) ? cnt_r + 1'b1 : '0;

  always_comb begin
    in_ready   = 1'b0;
    cmd.pix_en = 1'b0;
    cmd.op     = lfps_pkg::OP_NONE;
    case (state_r)
      lfps_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.pix_en = in_valid;
      end
      lfps_pkg::ST_DECIDE: begin
        if (stat.junction) begin
          if (stat.out_free) cmd.op = lfps_pkg::OP_DEC_INT;
        end else if (stat.have_win) begin
          cmd.op = lfps_pkg::OP_DIV_START;
        end else if (stat.out_free) begin
          cmd.op = lfps_pkg::OP_DEC_LOST;
        end
      end
      lfps_pkg::ST_DIV:    cmd.op = lfps_pkg::OP_DIV_STEP;
      lfps_pkg::ST_MEAN:   cmd.op = lfps_pkg::OP_MEAN;
      lfps_pkg::ST_MUL_P:  cmd.op = lfps_pkg::OP_MUL_P;
      lfps_pkg::ST_PROP:   cmd.op = lfps_pkg::OP_PROP;
      lfps_pkg::ST_UPD:    cmd.op = lfps_pkg::OP_UPD;
      lfps_pkg::ST_MUL_D:  cmd.op = lfps_pkg::OP_MUL_D;
      lfps_pkg::ST_DER:    cmd.op = lfps_pkg::OP_DER;
      lfps_pkg::ST_MUL_IL: cmd.op = lfps_pkg::OP_MUL_IL;
      lfps_pkg::ST_MUL_IH: cmd.op = lfps_pkg::OP_MUL_IH;
      lfps_pkg::ST_ISUM:   cmd.op = lfps_pkg::OP_ISUM;
      lfps_pkg::ST_INTG:   cmd.op = lfps_pkg::OP_INTG;
      lfps_pkg::ST_PID1:   cmd.op = lfps_pkg::OP_PID1;
      lfps_pkg::ST_PID2:   cmd.op = lfps_pkg::OP_PID2;
      lfps_pkg::ST_CLAMP:  cmd.op = lfps_pkg::OP_CLAMP;
      lfps_pkg::ST_MUL_WL: cmd.op = lfps_pkg::OP_MUL_WL;
      lfps_pkg::ST_MUL_WR: cmd.op = lfps_pkg::OP_MUL_WR;
      lfps_pkg::ST_LOAD: begin
        if (stat.out_free) cmd.op = lfps_pkg::OP_LOAD;
      end
      default: cmd.op = lfps_pkg::OP_NONE;
    endcase
  end

  `LFPS_ASSERT_NXT(a_frame_end_decides, in_valid && in_ready && frame_end, state_r == lfps_pkg::ST_DECIDE)
  `LFPS_ASSERT_IMP(a_div_count_bound, state_r == lfps_pkg::ST_DIV, cnt_r <= DIV_LAST)
  `LFPS_ASSERT_NXT(a_load_waits, state_r == lfps_pkg::ST_LOAD && !stat.out_free, state_r == lfps_pkg::ST_LOAD)

endmodule

// ----- hw/rtl/lfps_dp.sv -----
// Datapath with pixel counters, serial divider, shared multiplier and PID registers.
`include "line_follow_pid_steer_macros.svh"
module lfps_dp #(
  parameter int CENTER_COLUMN = lfps_pkg::CENTER_COLUMN_DEF,
  parameter int SCAN_ROW      = lfps_pkg::SCAN_ROW_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lfps_pkg::lfps_cmd_t  cmd,
  output lfps_pkg::lfps_stat_t stat,
  input  logic [7:0]           pixel_value,
  input  logic [8:0]           pixel_col,
  input  logic [7:0]           pixel_row,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic signed [8:0]    left_speed,
  output logic signed [8:0]    right_speed,
  output logic [1:0]           decision,
  output logic signed [18:0]   mean_offset
);

  localparam logic [7:0] ROW_SCAN = 8'(SCAN_ROW);
  localparam logic [7:0] ROW_LO   = 8'(SCAN_ROW - lfps_pkg::ROW_ABOVE);
  localparam logic [7:0] ROW_HI   = 8'(SCAN_ROW + lfps_pkg::ROW_BELOW);
  localparam logic [8:0] COL_C    = 9'(CENTER_COLUMN);
  localparam logic [8:0] COL_LO   = 9'(CENTER_COLUMN - lfps_pkg::WIN_LEFT);
  localparam logic [8:0] COL_HI   = 9'(CENTER_COLUMN + lfps_pkg::WIN_RIGHT);

  localparam logic signed [16:0] OSUM_MAX = 17'sd32767;
  localparam logic signed [16:0] OSUM_MIN = -17'sd32768;
  localparam logic signed [48:0] I48_MAX  = $signed({2'b00, {47{1'b1}}});
  localparam logic signed [48:0] I48_MIN  = $signed({2'b11, {47{1'b0}}});
  localparam logic signed [63:0] PID_HI   = 64'(lfps_pkg::PID_LIM);
  localparam logic signed [63:0] PID_LO   = -64'(lfps_pkg::PID_LIM);

  function automatic logic signed [63:0] trunc_q(input logic signed [63:0] x);
    logic signed [63:0] bias;
    bias = x[63] ? 64'((1 << lfps_pkg::Q_FRAC) - 1) : 64'sd0;
    return (x + bias) >>> lfps_pkg::Q_FRAC;
  endfunction

  function automatic logic signed [8:0] wheel(input logic signed [45:0] prod,
                                              input logic [7:0] base);
    logic [10:0]        base5;
    logic signed [35:0] num;
    logic [35:0]        mag;
    logic [18:0]        t;
    logic [24:0]        m;
    logic [7:0]         q;
    base5 = (11'(base) << 2) + 11'(base);
    num   = $signed(prod[35:0]) + $signed(36'({base5, {lfps_pkg::WHEEL_SHIFT{1'b0}}}));
    mag   = num[35] ? 36'(-num) : 36'(num);
    t     = mag[35:lfps_pkg::WHEEL_SHIFT];
    m     = 25'(t[10:0]) * 25'(lfps_pkg::RECIP5);
    if (t >= 19'(lfps_pkg::WHEEL_SAT_T)) begin
      q = 8'd255;
    end else begin
      q = m[lfps_pkg::RECIP_SHIFT+7:lfps_pkg::RECIP_SHIFT];
    end
    return num[35] ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  logic [15:0] kp_r, kd_r, ki_r;
  logic [7:0]  thr_r, jcnt_r, base_r;

  logic [7:0]         lcnt_r;
  logic [8:0]         wcnt_r;
  logic signed [15:0] osum_r;

  logic [27:0]        quo_r;
  logic [8:0]         rem_r;
  logic [8:0]         dvs_r;
  logic               neg_r;
  logic signed [18:0] mean_r;
  logic signed [45:0] prod_r;
  logic signed [23:0] prop_r;
  logic signed [23:0] prev_r;
  logic signed [28:0] diff20_r;
  logic signed [32:0] der_r;
  logic signed [47:0] integ_r;
  logic [39:0]        plo_r;
  logic signed [63:0] acc_r;
  logic signed [24:0] pidc_r;
  logic               pos_r;
  logic signed [8:0]  wl_r;

  logic               out_valid_r;
  logic signed [8:0]  out_left_r, out_right_r;
  logic [1:0]         out_dec_r;
  logic signed [18:0] out_mean_r;

  logic               bright, in_left, in_win;
  logic signed [9:0]  offset;
  logic signed [16:0] osum_ext;
  logic signed [15:0] osum_nxt;
  logic [15:0]        osum_mag;
  logic [9:0]         div_sh;
  logic               div_ge;
  logic [8:0]         rem_nxt;
  logic signed [18:0] mean_nxt;
  logic signed [24:0] diff;
  logic signed [28:0] diff20_nxt;
  logic signed [48:0] isum;
  logic signed [47:0] integ_nxt;
  logic signed [24:0] pidc_nxt;
  logic signed [28:0] mul_a;
  logic [15:0]        mul_b;
  logic signed [45:0] mul_p;
  logic               load_out;

  always_comb begin
    bright   = pixel_value > thr_r;
    in_left  = (pixel_row == ROW_SCAN) && (pixel_col < COL_C);
    in_win   = (pixel_row >= ROW_LO) && (pixel_row <= ROW_HI) &&
               (pixel_col >= COL_LO) && (pixel_col <= COL_HI);
    offset   = $signed({1'b0, pixel_col}) - $signed({1'b0, COL_C});
    osum_ext = 17'(osum_r) + 17'(offset);
    if (osum_ext > OSUM_MAX) begin
      osum_nxt = 16'(OSUM_MAX);
    end else if (osum_ext < OSUM_MIN) begin
      osum_nxt = 16'(OSUM_MIN);
    end else begin
      osum_nxt = 16'(osum_ext);
    end
  end

  always_comb begin
    osum_mag = osum_r[15] ? 16'(-osum_r) : 16'(osum_r);
    div_sh   = {rem_r, quo_r[27]};
    div_ge   = div_sh >= {1'b0, dvs_r};
    rem_nxt  = div_ge ? 9'(div_sh - {1'b0, dvs_r}) : div_sh[8:0];
    if (!neg_r) begin
      mean_nxt = (quo_r > 28'(lfps_pkg::MEAN_MAX)) ? 19'(lfps_pkg::MEAN_MAX) : 19'(quo_r);
    end else begin
      mean_nxt = (quo_r > 28'(lfps_pkg::MEAN_NEG_MAG)) ?
                 -19'(lfps_pkg::MEAN_NEG_MAG) : -19'(quo_r);
    end
  end

  always_comb begin
    diff       = 25'(prop_r) - 25'(prev_r);
    diff20_nxt = (29'(diff) <<< 4) + (29'(diff) <<< 2);
    isum       = 49'(integ_r) + 49'(prop_r);
    if (isum > I48_MAX) begin
      integ_nxt = 48'(I48_MAX);
    end else if (isum < I48_MIN) begin
      integ_nxt = 48'(I48_MIN);
    end else begin
      integ_nxt = 48'(isum);
    end
    if (acc_r > PID_HI) begin
      pidc_nxt = 25'(PID_HI);
    end else if (acc_r < PID_LO) begin
      pidc_nxt = 25'(PID_LO);
    end else begin
      pidc_nxt = 25'(acc_r);
    end
  end

  always_comb begin
    case (cmd.op)
      lfps_pkg::OP_MUL_P: begin
        mul_a = 29'(mean_r);
        mul_b = kp_r;
      end
      lfps_pkg::OP_MUL_D: begin
        mul_a = diff20_r;
        mul_b = kd_r;
      end
      lfps_pkg::OP_MUL_IL: begin
        mul_a = $signed({5'b0, integ_r[23:0]});
        mul_b = ki_r;
      end
      lfps_pkg::OP_MUL_IH: begin
        mul_a = 29'($signed(integ_r[47:24]));
        mul_b = ki_r;
      end
      lfps_pkg::OP_MUL_WL: begin
        mul_a = 29'(pidc_r);
        mul_b = pos_r ? 16'(lfps_pkg::SCALE_SHORT) : 16'(lfps_pkg::SCALE_LONG);
      end
      lfps_pkg::OP_MUL_WR: begin
        mul_a = 29'(-pidc_r);
        mul_b = pos_r ? 16'(lfps_pkg::SCALE_LONG) : 16'(lfps_pkg::SCALE_SHORT);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * $signed({1'b0, mul_b});
  end

  assign load_out = (cmd.op == lfps_pkg::OP_DEC_INT) || (cmd.op == lfps_pkg::OP_DEC_LOST) ||
                    (cmd.op == lfps_pkg::OP_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r   <= lfps_pkg::PROP_GAIN_RST;
      kd_r   <= lfps_pkg::DERIV_GAIN_RST;
      ki_r   <= lfps_pkg::INTEG_GAIN_RST;
      thr_r  <= lfps_pkg::THRESHOLD_RST;
      jcnt_r <= lfps_pkg::JUNCTION_RST;
      base_r <= lfps_pkg::BASE_SPEED_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lfps_pkg::REG_PROP_GAIN:  kp_r   <= cfg_data;
        lfps_pkg::REG_DERIV_GAIN: kd_r   <= cfg_data;
        lfps_pkg::REG_INTEG_GAIN: ki_r   <= cfg_data;
        lfps_pkg::REG_THRESHOLD:  thr_r  <= cfg_data[7:0];
        lfps_pkg::REG_JUNCTION:   jcnt_r <= cfg_data[7:0];
        lfps_pkg::REG_BASE_SPEED: base_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcnt_r <= '0;
      wcnt_r <= '0;
      osum_r <= '0;
    end else if (cmd.pix_en) begin
      if (bright && in_left && (lcnt_r != 8'hFF)) lcnt_r <= lcnt_r + 1'b1;
      if (bright && in_win) begin
        if (wcnt_r != 9'h1FF) wcnt_r <= wcnt_r + 1'b1;
        osum_r <= osum_nxt;
      end
    end else if ((cmd.op == lfps_pkg::OP_DEC_INT) || (cmd.op == lfps_pkg::OP_DEC_LOST) ||
                 (cmd.op == lfps_pkg::OP_DIV_START)) begin
      lcnt_r <= '0;
      wcnt_r <= '0;
      osum_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      integ_r <= '0;
    end else if (cmd.op == lfps_pkg::OP_UPD) begin
      prev_r  <= prop_r;
      integ_r <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      lfps_pkg::OP_DIV_START: begin
        quo_r <= {osum_mag, {lfps_pkg::Q_FRAC{1'b0}}};
        rem_r <= '0;
        dvs_r <= wcnt_r;
        neg_r <= osum_r[15];
      end
      lfps_pkg::OP_DIV_STEP: begin
        quo_r <= {quo_r[26:0], div_ge};
        rem_r <= rem_nxt;
      end
      lfps_pkg::OP_MEAN:   mean_r   <= mean_nxt;
      lfps_pkg::OP_MUL_P:  prod_r   <= mul_p;
      lfps_pkg::OP_PROP:   prop_r   <= 24'(trunc_q(64'(prod_r)));
      lfps_pkg::OP_UPD:    diff20_r <= diff20_nxt;
      lfps_pkg::OP_MUL_D:  prod_r   <= mul_p;
      lfps_pkg::OP_DER:    der_r    <= 33'(trunc_q(64'(prod_r)));
      lfps_pkg::OP_MUL_IL: prod_r   <= mul_p;
      lfps_pkg::OP_MUL_IH: begin
        plo_r  <= prod_r[39:0];
        prod_r <= mul_p;
      end
      lfps_pkg::OP_ISUM:   acc_r <= (64'(prod_r) <<< 24) + $signed({24'b0, plo_r});
      lfps_pkg::OP_INTG:   acc_r <= trunc_q(acc_r);
      lfps_pkg::OP_PID1:   acc_r <= acc_r + 64'(der_r);
      lfps_pkg::OP_PID2:   acc_r <= acc_r + 64'(prop_r);
      lfps_pkg::OP_CLAMP: begin
        pidc_r <= pidc_nxt;
        pos_r  <= acc_r > 64'sd0;
      end
      lfps_pkg::OP_MUL_WL: prod_r <= mul_p;
      lfps_pkg::OP_MUL_WR: begin
        wl_r   <= wheel(prod_r, base_r);
        prod_r <= mul_p;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      lfps_pkg::OP_DEC_INT: begin
        out_left_r  <= $signed({1'b0, base_r});
        out_right_r <= $signed({1'b0, base_r});
        out_dec_r   <= lfps_pkg::DEC_JUNCTION;
        out_mean_r  <= '0;
      end
      lfps_pkg::OP_DEC_LOST: begin
        out_left_r  <= $signed({1'b0, base_r});
        out_right_r <= -$signed({1'b0, base_r});
        out_dec_r   <= lfps_pkg::DEC_LOST;
        out_mean_r  <= '0;
      end
      lfps_pkg::OP_LOAD: begin
        out_left_r  <= wl_r;
        out_right_r <= wheel(prod_r, base_r);
        out_dec_r   <= lfps_pkg::DEC_FOLLOW;
        out_mean_r  <= mean_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.junction = lcnt_r > jcnt_r;
  assign stat.have_win = wcnt_r != 9'd0;
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign left_speed  = out_left_r;
  assign right_speed = out_right_r;
  assign decision    = out_dec_r;
  assign mean_offset = out_mean_r;

  `LFPS_ASSERT_IMP(a_empty_window_sum, wcnt_r == 9'd0, osum_r == 16'sd0)
  `LFPS_ASSERT_NXT(a_div_rem_bound, cmd.op == lfps_pkg::OP_DIV_STEP, rem_r < dvs_r)
  `LFPS_ASSERT_NXT(a_decide_clears, cmd.op == lfps_pkg::OP_DEC_INT || cmd.op == lfps_pkg::OP_DEC_LOST || cmd.op == lfps_pkg::OP_DIV_START, lcnt_r == 8'd0 && wcnt_r == 9'd0)

endmodule

// ----- hw/rtl/line_follow_pid_steer.sv -----
// Top level of the camera line follower with PID wheel steering.
//
// Channel   Direction  Handshake     Payload
// in_pix    in         valid/ready   pixel_value, pixel_col, pixel_row, frame_end
// out_res   out        valid/ready   left_speed, right_speed, decision, mean_offset
// cfg       in         cfg_we        cfg_index, cfg_data
//
// Pixels are taken one per cycle while the controller is idle.
// After a frame_end transfer, a junction or line-lost result loads straight from the decide
// step, and a follow result passes through the bit-serial mean divider and then the
// shared 29x17 multiplier passes and sequencing steps; no pixel is taken meanwhile.
// Reset is synchronous: registers return to defaults, counters and PID state clear.
// A result waits in the output register while pixels keep flowing; the next decision
// holds at its load step until that register is free.
module line_follow_pid_steer #(
  parameter int CENTER_COLUMN = lfps_pkg::CENTER_COLUMN_DEF,
  parameter int SCAN_ROW      = lfps_pkg::SCAN_ROW_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lfps_pix_if.sink    in_pix,
  lfps_res_if.source  out_res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  lfps_pkg::lfps_cmd_t  cmd;
  lfps_pkg::lfps_stat_t stat;

  lfps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_pix.valid),
    .frame_end (in_pix.frame_end),
    .in_ready  (in_pix.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lfps_dp #(
    .CENTER_COLUMN (CENTER_COLUMN),
    .SCAN_ROW      (SCAN_ROW)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .pixel_value (in_pix.pixel_value),
    .pixel_col   (in_pix.pixel_col),
    .pixel_row   (in_pix.pixel_row),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_ready   (out_res.ready),
    .out_valid   (out_res.valid),
    .left_speed  (out_res.left_speed),
    .right_speed (out_res.right_speed),
    .decision    (out_res.decision),
    .mean_offset (out_res.mean_offset)
  );

endmodule

// ----- tb/line_follow_pid_steer_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the line follower steering block, driven by pixel frames.
module line_follow_pid_steer_tb;

  localparam int     CENTER        = lfps_pkg::CENTER_COLUMN_DEF;
  localparam int     SCAN          = lfps_pkg::SCAN_ROW_DEF;
  localparam int     WIN_LO        = CENTER - lfps_pkg::WIN_LEFT;
  localparam int     WIN_HI        = CENTER + lfps_pkg::WIN_RIGHT;
  localparam int     ROW_LO        = SCAN - lfps_pkg::ROW_ABOVE;
  localparam int     ROW_HI        = SCAN + lfps_pkg::ROW_BELOW;
  localparam longint Q_ONE         = longint'(1) << lfps_pkg::Q_FRAC;
  localparam longint WHEEL_SPAN    = 160;
  localparam longint WHEEL_DIV     = WHEEL_SPAN * Q_ONE;
  localparam longint WHEEL_MAX     = 255;
  localparam longint DER_SCALE     = 20;
  localparam longint ISUM_MAX      = (longint'(1) <<< 47) - 1;
  localparam longint ISUM_MIN      = -(longint'(1) <<< 47);
  localparam longint OFFSET_MAX    = 32767;
  localparam longint OFFSET_MIN    = -32768;
  localparam longint MEAN_HI       = longint'(lfps_pkg::MEAN_MAX);
  localparam longint MEAN_LO       = -longint'(lfps_pkg::MEAN_NEG_MAG);
  localparam longint SHORT_ARM     = longint'(lfps_pkg::SCALE_SHORT);
  localparam longint LONG_ARM      = longint'(lfps_pkg::SCALE_LONG);
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;
  localparam int     LEFT_FLOOD    = 258;
  localparam int     WINDOW_FLOOD  = 680;
  localparam int     SETTLE_CYCLES = 64;
  localparam int     QUIET_LIMIT   = 5000;

  typedef struct packed {
    logic [7:0] value;
    logic [8:0] col;
    logic [7:0] row;
    logic       last;
  } pixel_t;

  typedef struct {
    logic signed [8:0]  left;
    logic signed [8:0]  right;
    logic [1:0]         decision;
    logic signed [18:0] mean;
  } wheel_cmd_t;

  typedef enum logic [1:0] {
    FRAME_TRACK,
    FRAME_CROSS,
    FRAME_EMPTY,
    FRAME_NOISE
  } frame_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [15:0] cfg_data = 16'd0;

  lfps_pix_if pix_ch ();
  lfps_res_if res_ch ();

  line_follow_pid_steer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (pix_ch),
    .out_res   (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  logic [15:0] kp_reg   = lfps_pkg::PROP_GAIN_RST;
  logic [15:0] kd_reg   = lfps_pkg::DERIV_GAIN_RST;
  logic [15:0] ki_reg   = lfps_pkg::INTEG_GAIN_RST;
  logic [7:0]  thr_reg  = lfps_pkg::THRESHOLD_RST;
  logic [7:0]  junc_reg = lfps_pkg::JUNCTION_RST;
  logic [7:0]  base_reg = lfps_pkg::BASE_SPEED_RST;

  logic [7:0] left_hits = 8'd0;
  logic [8:0] win_hits = 9'd0;
  int         offset_acc = 0;
  int         last_prop = 0;
  longint     integ_acc = 0;

  pixel_t     pixel_q[$];
  wheel_cmd_t wheel_cmd_q[$];
  pixel_t     shown_px;
  int         pushed_count = 0;
  int         accepted_count = 0;
  int         mismatch_count = 0;
  int         quiet_cycles = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint wheel_speed(input longint pid, input longint scale,
                                         input longint base);
    longint num;
    num = pid * scale + base * WHEEL_DIV;
    return clamp(num / WHEEL_DIV, -WHEEL_MAX, WHEEL_MAX);
  endfunction

  task automatic compute_wheel_cmd(input pixel_t p);
    longint     mean, prop, der, intg, pid, left, right, hits, base;
    wheel_cmd_t cmd;
    if (p.value > thr_reg) begin
      if (p.row == SCAN && p.col < CENTER && left_hits != 8'hFF) left_hits++;
      if (p.row >= ROW_LO && p.row <= ROW_HI && p.col >= WIN_LO && p.col <= WIN_HI) begin
        if (win_hits != 9'h1FF) win_hits++;
        offset_acc = int'(clamp(longint'(offset_acc) + longint'(p.col) - CENTER,
                                OFFSET_MIN, OFFSET_MAX));
      end
    end
    if (!p.last) return;
    base = longint'(base_reg);
    mean = 0;
    if (left_hits > junc_reg) begin
      cmd.decision = lfps_pkg::DEC_JUNCTION;
      left = base;
      right = base;
    end else if (win_hits != 9'd0) begin
      cmd.decision = lfps_pkg::DEC_FOLLOW;
      hits = longint'(win_hits);
      mean = clamp(longint'(offset_acc) * Q_ONE / hits, MEAN_LO, MEAN_HI);
      prop = mean * longint'(kp_reg) / Q_ONE;
      der = (prop - last_prop) * DER_SCALE * longint'(kd_reg) / Q_ONE;
      last_prop = int'(prop);
      integ_acc = clamp(integ_acc + prop, ISUM_MIN, ISUM_MAX);
      intg = integ_acc * longint'(ki_reg) / Q_ONE;
      pid = prop + der + intg;
      if (pid > 0) begin
        left = wheel_speed(pid, SHORT_ARM, base);
        right = wheel_speed(-pid, LONG_ARM, base);
      end else begin
        left = wheel_speed(pid, LONG_ARM, base);
        right = wheel_speed(-pid, SHORT_ARM, base);
      end
    end else begin
      cmd.decision = lfps_pkg::DEC_LOST;
      left = base;
      right = -base;
    end
    left_hits = 8'd0;
    win_hits = 9'd0;
    offset_acc = 0;
    cmd.left = left[8:0];
    cmd.right = right[8:0];
    cmd.mean = mean[18:0];
    wheel_cmd_q.push_back(cmd);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    $display("%0t: mismatch on %0s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pix_ch.valid <= 1'b0;
    end else begin
      if (pix_ch.valid && pix_ch.ready) begin
        compute_wheel_cmd(shown_px);
        accepted_count++;
      end
      if (!pix_ch.valid || pix_ch.ready) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          shown_px = pixel_q.pop_front();
          pix_ch.valid <= 1'b1;
          pix_ch.pixel_value <= shown_px.value;
          pix_ch.pixel_col <= shown_px.col;
          pix_ch.pixel_row <= shown_px.row;
          pix_ch.frame_end <= shown_px.last;
        end else begin
          pix_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    wheel_cmd_t want;
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (wheel_cmd_q.size() == 0) begin
          report_mismatch("result with nothing pending", longint'(res_ch.decision),
                          longint'(0));
        end else begin
          want = wheel_cmd_q.pop_front();
          if (res_ch.left_speed !== want.left)
            report_mismatch("left_speed", longint'(res_ch.left_speed), longint'(want.left));
          if (res_ch.right_speed !== want.right)
            report_mismatch("right_speed", longint'(res_ch.right_speed),
                            longint'(want.right));
          if (res_ch.decision !== want.decision)
            report_mismatch("decision", longint'(res_ch.decision), longint'(want.decision));
          if (res_ch.mean_offset !== want.mean)
            report_mismatch("mean_offset", longint'(res_ch.mean_offset), longint'(want.mean));
        end
      end
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAIL line_follow_pid_steer");
    $finish;
  end

  function automatic pixel_t mk_px(input int v, input int c, input int r, input bit e);
    pixel_t p;
    p.value = 8'(v);
    p.col = 9'(c);
    p.row = 8'(r);
    p.last = e;
    return p;
  endfunction

  function automatic logic [7:0] pick_value(input bit bright);
    if (bright && thr_reg != 8'hFF) return 8'($urandom_range(255, int'(thr_reg) + 1));
    return 8'($urandom_range(255));
  endfunction

  function automatic pixel_t any_pixel();
    return mk_px(int'($urandom_range(255)), int'($urandom_range(511)),
                 int'($urandom_range(255)), 1'b0);
  endfunction

  function automatic pixel_t left_pixel();
    pixel_t p;
    p = mk_px(int'(pick_value(1'b1)), int'($urandom_range(CENTER)), SCAN, 1'b0);
    if ($urandom_range(7) == 0) p.row = 8'(SCAN + 1);
    return p;
  endfunction

  function automatic pixel_t track_pixel(input int aim);
    pixel_t p;
    int     r;
    r = int'($urandom_range(9));
    p.value = pick_value($urandom_range(3) != 0);
    p.last = 1'b0;
    p.row = 8'($urandom_range(ROW_HI + 1, ROW_LO - 1));
    if (r < 5) p.col = 9'(aim + int'($urandom_range(6)) - 3);
    else if (r < 8) p.col = 9'($urandom_range(WIN_HI + 1, WIN_LO - 1));
    else if (r == 8) p = left_pixel();
    else p = any_pixel();
    return p;
  endfunction

  task automatic push_pixel(input pixel_t p);
    pixel_q.push_back(p);
    pushed_count++;
  endtask

  task automatic build_frame(input frame_kind_t kind);
    int     n, i, aim;
    pixel_t p;
    aim = WIN_LO - 1 + int'($urandom_range(WIN_HI - WIN_LO + 2));
    case (kind)
      FRAME_TRACK: n = int'($urandom_range(16, 1));
      FRAME_CROSS: n = int'(junc_reg) + int'($urandom_range(4, 1));
      FRAME_EMPTY: n = int'($urandom_range(8, 1));
      default:     n = int'($urandom_range(12, 1));
    endcase
    for (i = 0; i < n; i++) begin
      case (kind)
        FRAME_TRACK: p = track_pixel(aim);
        FRAME_CROSS: p = ($urandom_range(7) == 0) ? track_pixel(aim) : left_pixel();
        FRAME_EMPTY: begin
          if ($urandom_range(1) == 0) begin
            p = any_pixel();
          end else begin
            p = track_pixel(aim);
            p.value = 8'($urandom_range(int'(thr_reg)));
          end
        end
        default: begin
          p = any_pixel();
          p.last = ($urandom_range(5) == 0);
        end
      endcase
      if (i == n - 1) p.last = 1'b1;
      push_pixel(p);
    end
  endtask

  task automatic random_frames(input int budget);
    int start, r;
    start = pushed_count;
    while (pushed_count - start < budget) begin
      r = int'($urandom_range(99));
      if (r < 62) build_frame(FRAME_TRACK);
      else if (r < 74 && junc_reg <= 8'd24) build_frame(FRAME_CROSS);
      else if (r < 86) build_frame(FRAME_EMPTY);
      else build_frame(FRAME_NOISE);
    end
  endtask

  task automatic wait_drained();
    while (accepted_count != pushed_count || wheel_cmd_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      lfps_pkg::REG_PROP_GAIN:  kp_reg = data;
      lfps_pkg::REG_DERIV_GAIN: kd_reg = data;
      lfps_pkg::REG_INTEG_GAIN: ki_reg = data;
      lfps_pkg::REG_THRESHOLD:  thr_reg = data[7:0];
      lfps_pkg::REG_JUNCTION:   junc_reg = data[7:0];
      lfps_pkg::REG_BASE_SPEED: base_reg = data[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] kp, input logic [15:0] kd,
                            input logic [15:0] ki, input logic [7:0] thr,
                            input logic [7:0] junc, input logic [7:0] base);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(lfps_pkg::REG_PROP_GAIN, kp);
    write_reg(lfps_pkg::REG_DERIV_GAIN, kd);
    write_reg(lfps_pkg::REG_INTEG_GAIN, ki);
    write_reg(lfps_pkg::REG_THRESHOLD, {junk[31:24], thr});
    write_reg(lfps_pkg::REG_JUNCTION, {junk[23:16], junc});
    write_reg(lfps_pkg::REG_BASE_SPEED, {junk[15:8], base});
    write_reg(REG_SPARE_A, 16'($urandom));
    write_reg(REG_SPARE_B, 16'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int i;
    pix_ch.valid = 1'b0;
    pix_ch.pixel_value = 8'd0;
    pix_ch.pixel_col = 9'd0;
    pix_ch.pixel_row = 8'd0;
    pix_ch.frame_end = 1'b0;
    res_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings first, with edge columns, rows and brightness levels.
    send_idle_pct = 37;
    recv_idle_pct = 69;
    push_pixel(mk_px(255, WIN_LO, ROW_LO, 1'b1));
    push_pixel(mk_px(255, WIN_HI, ROW_HI, 1'b1));
    push_pixel(mk_px(int'(lfps_pkg::THRESHOLD_RST), CENTER, SCAN, 1'b1));
    push_pixel(mk_px(int'(lfps_pkg::THRESHOLD_RST) + 1, CENTER, SCAN - 1, 1'b0));
    push_pixel(mk_px(255, 511, 255, 1'b1));
    push_pixel(mk_px(255, WIN_HI + 1, SCAN, 1'b0));
    push_pixel(mk_px(255, WIN_LO - 1, SCAN - 1, 1'b0));
    push_pixel(mk_px(255, CENTER - 10, ROW_LO - 1, 1'b0));
    push_pixel(mk_px(255, CENTER - 10, ROW_HI + 1, 1'b0));
    push_pixel(mk_px(0, 0, 0, 1'b1));
    push_pixel(mk_px(255, CENTER - 1, SCAN, 1'b0));
    push_pixel(mk_px(200, 0, SCAN, 1'b0));
    push_pixel(mk_px(255, CENTER - 10, SCAN, 1'b1));
    push_pixel(mk_px(0, 0, 0, 1'b0));
    push_pixel(mk_px(255, 319, 239, 1'b1));
    push_pixel(mk_px(255, CENTER + 40, ROW_LO, 1'b0));
    push_pixel(mk_px(255, CENTER - 40, ROW_HI, 1'b1));
    random_frames(200);
    wait_drained();

    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd0, 8'd0, 8'd255);
    push_pixel(mk_px(255, 0, SCAN, 1'b1));
    push_pixel(mk_px(1, CENTER - 1, SCAN, 1'b1));
    push_pixel(mk_px(0, CENTER, SCAN, 1'b1));
    random_frames(150);
    wait_drained();

    send_idle_pct = 69;
    recv_idle_pct = 37;
    set_config(16'd0, 16'd0, 16'd0, 8'd255, 8'd160, 8'd0);
    random_frames(40);
    wait_drained();

    set_config(16'($urandom_range(65535)), 16'($urandom_range(65535)),
               16'($urandom_range(200)), 8'($urandom_range(200, 60)),
               8'($urandom_range(20, 2)), 8'($urandom_range(255)));
    random_frames(150);
    wait_drained();

    // Saturated left count gives a junction; saturated window sums clamp the mean.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(16'd4096, 16'd1024, 16'd16, 8'd100, 8'd160, 8'd128);
    for (i = 0; i < LEFT_FLOOD; i++)
      push_pixel(mk_px(255, int'($urandom_range(CENTER - 1)), SCAN, 1'b0));
    push_pixel(mk_px(255, CENTER, SCAN, 1'b1));
    for (i = 0; i < WINDOW_FLOOD; i++) push_pixel(mk_px(255, WIN_HI, ROW_LO, 1'b0));
    push_pixel(mk_px(0, 0, 0, 1'b1));
    random_frames(60);
    wait_drained();

    set_config(16'($urandom_range(65535)), 16'($urandom_range(65535)),
               16'($urandom_range(65535)), 8'($urandom_range(254)),
               8'($urandom_range(160)), 8'($urandom_range(255)));
    random_frames(120);
    wait_drained();

    if (wheel_cmd_q.size() != 0)
      report_mismatch("results never delivered", longint'(0), longint'(wheel_cmd_q.size()));
    if (mismatch_count == 0) begin
      $display("PASS line_follow_pid_steer");
    end else begin
      $display("FAIL line_follow_pid_steer");
    end
    $finish;
  end

endmodule

// ----- line_follow_pid_steer.f -----
+incdir+hw/rtl
hw/rtl/lfps_pkg.sv
hw/rtl/lfps_pix_if.sv
hw/rtl/lfps_res_if.sv
hw/rtl/lfps_ctrl.sv
hw/rtl/lfps_dp.sv
hw/rtl/line_follow_pid_steer.sv
tb/line_follow_pid_steer_tb.sv
